>>> rtl/twt_pkg.sv
// ----------------------------------------------------------------------------
// twt_pkg
// Shared constants, command encoding and queue types for the timing wheel
// timer table.
// ----------------------------------------------------------------------------
package twt_pkg;

    localparam int NUM_TIMERS  = 16;
    localparam int WHEEL_SLOTS = 10;

    localparam int REQ_W  = 2;
    localparam int ID_W   = 4;
    localparam int IVL_W  = 16;
    localparam int ARG_W  = 32;
    localparam int ROT_W  = 16;
    localparam int SLOT_W = (WHEEL_SLOTS > 1) ? $clog2(WHEEL_SLOTS) : 1;

    // depth of the command queue between front and back end
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // slot + interval, and the reciprocal used to split it into slot and turns
    localparam int    POS_W       = IVL_W + 1;
    localparam int    RECIP_SHIFT = POS_W + SLOT_W;
    localparam int    RECIP_W     = RECIP_SHIFT;
    localparam int    PROD_W      = POS_W + RECIP_W;
    localparam longint RECIP_L    =
        ((longint'(1) << RECIP_SHIFT) + longint'(WHEEL_SLOTS) - 1) / longint'(WHEEL_SLOTS);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

    // request codes on the input
    localparam logic [REQ_W-1:0] REQ_START = 2'd0;
    localparam logic [REQ_W-1:0] REQ_STOP  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TICK  = 2'd2;

    typedef enum logic [1:0] {
        K_START,
        K_STOP,
        K_TICK
    } t_kind;

    typedef struct packed {
        t_kind                   kind;
        logic [ID_W-1:0]         id;
        logic [IVL_W-1:0]        ivl;
        logic signed [ARG_W-1:0] arg;
        logic                    silent;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_head;

endpackage

>>> rtl/twt_front.sv
// ----------------------------------------------------------------------------
// twt_front
// Accepts request items, drops those that do nothing, normalises the
// interval and queues the rest for the back end in a two-entry queue.
// ----------------------------------------------------------------------------
module twt_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [twt_pkg::REQ_W-1:0]       i_req_type,
    input  logic [twt_pkg::ID_W-1:0]        i_timer_id,
    input  logic [twt_pkg::IVL_W-1:0]       i_interval,
    input  logic signed [twt_pkg::ARG_W-1:0] i_callback_arg,
    input  logic                            i_silent_stop,
    output twt_pkg::t_q_head                o_head,
    input  logic                            i_pop
);
    import twt_pkg::*;

    t_cmd             cmd;
    logic             keep;
    logic             id_ok;
    logic             push;

    t_cmd               r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic [Q_CNT_W-1:0] n_count;

    assign id_ok = ({1'b0, i_timer_id} < (ID_W + 1)'(NUM_TIMERS));

    always_comb begin
        cmd.kind   = K_TICK;
        cmd.id     = i_timer_id;
        cmd.ivl    = (i_interval == '0) ? IVL_W'(1) : i_interval;
        cmd.arg    = i_callback_arg;
        cmd.silent = i_silent_stop;
        keep       = 1'b0;
        unique case (i_req_type)
            REQ_START: begin
                cmd.kind = K_START;
                keep     = id_ok;
            end
            REQ_STOP: begin
                cmd.kind = K_STOP;
                keep     = id_ok;
            end
            REQ_TICK: begin
                cmd.kind = K_TICK;
                keep     = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    // ignored requests are accepted and dropped here
    assign o_in_stall = (r_count == Q_CNT_W'(Q_DEPTH));
    assign push       = i_in_valid && !o_in_stall && keep;

    always_comb begin
        n_count = r_count;
        if (push && !i_pop) begin
            n_count = r_count + Q_CNT_W'(1);
        end else if (!push && i_pop) begin
            n_count = r_count - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_q[r_wr_ptr] <= cmd;
                r_wr_ptr      <= (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ?
                                 '0 : r_wr_ptr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ?
                            '0 : r_rd_ptr + Q_PTR_W'(1);
            end
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_q[r_rd_ptr];

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count out of range");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("pop from empty queue");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !i_pop) |=> r_count == $past(r_count) + Q_CNT_W'(1))
        else $error("queue count lost a push");

endmodule

>>> rtl/twt_back.sv
// ----------------------------------------------------------------------------
// twt_back
// Holds the timer table and the wheel, carries out start, stop and tick
// commands and drives the registered report output.
// ----------------------------------------------------------------------------
module twt_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  twt_pkg::t_q_head                 i_head,
    output logic                             o_pop,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [twt_pkg::ID_W-1:0]         o_expired_timer,
    output logic signed [twt_pkg::ARG_W-1:0] o_expired_arg,
    output logic                             o_cause,
    output logic                             o_last
);
    import twt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START_Q,
        S_START_W,
        S_TICK_CMP,
        S_EMIT
    } t_state;

    t_state                  r_state;

    logic [NUM_TIMERS-1:0]   r_valid;
    logic [SLOT_W-1:0]       r_slot [NUM_TIMERS];
    logic [ROT_W-1:0]        r_rot  [NUM_TIMERS];
    logic signed [ARG_W-1:0] r_arg  [NUM_TIMERS];

    logic [SLOT_W-1:0]       r_cur_slot;
    logic [ROT_W-1:0]        r_cur_rot;

    logic [ID_W-1:0]         r_id;
    logic [IVL_W-1:0]        r_ivl;
    logic signed [ARG_W-1:0] r_arg_in;
    logic [POS_W-1:0]        r_pos;
    logic [POS_W-1:0]        r_quot;
    logic [NUM_TIMERS-1:0]   r_mask;

    logic                    r_out_valid;
    logic [ID_W-1:0]         r_out_timer;
    logic signed [ARG_W-1:0] r_out_arg;
    logic                    r_out_cause;
    logic                    r_out_last;

    t_cmd                    head;
    logic                    out_free;
    logic                    load_out;
    logic [POS_W-1:0]        pos;
    logic [PROD_W-1:0]       prod;
    logic [POS_W-1:0]        rem;
    logic [NUM_TIMERS-1:0]   cmp;
    logic [ID_W-1:0]         pick_idx;
    logic [NUM_TIMERS-1:0]   rest;
    logic                    wrap;

    assign head     = i_head.cmd;
    assign out_free = !r_out_valid || !i_out_stall;
    assign o_pop    = i_head.valid && (r_state == S_IDLE) &&
                      ((head.kind != K_STOP) || out_free);

    // a report is loaded by a loud stop of an armed timer or by the tick scan
    assign load_out = ((r_state == S_IDLE) && o_pop && (head.kind == K_STOP) &&
                       r_valid[head.id] && !head.silent) ||
                      ((r_state == S_EMIT) && out_free);

    // quotient by reciprocal, exact for every sum below 2^POS_W
    assign pos  = POS_W'(r_cur_slot) + POS_W'(r_ivl);
    assign prod = PROD_W'(pos) * PROD_W'(RECIP);
    assign rem  = r_pos - POS_W'(r_quot * POS_W'(WHEEL_SLOTS));
    assign wrap = (r_cur_slot == SLOT_W'(WHEEL_SLOTS - 1));

    always_comb begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
            cmp[i] = r_valid[i] && (r_slot[i] == r_cur_slot) && (r_rot[i] == r_cur_rot);
        end
    end

    // lowest due timer goes first
    always_comb begin
        pick_idx = '0;
        for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                pick_idx = ID_W'(i);
            end
        end
        rest           = r_mask;
        rest[pick_idx] = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_cur_slot  <= '0;
            r_cur_rot   <= '0;
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        unique case (head.kind)
                            K_START: begin
                                r_id     <= head.id;
                                r_ivl    <= head.ivl;
                                r_arg_in <= head.arg;
                                r_state  <= S_START_Q;
                            end
                            K_STOP: begin
                                if (r_valid[head.id]) begin
                                    r_valid[head.id] <= 1'b0;
                                    if (!head.silent) begin
                                        r_out_timer <= head.id;
                                        r_out_arg   <= r_arg[head.id];
                                        r_out_cause <= 1'b1;
                                        r_out_last  <= 1'b1;
                                    end
                                end
                            end
                            K_TICK: begin
                                if (wrap) begin
                                    r_cur_slot <= '0;
                                    r_cur_rot  <= r_cur_rot + ROT_W'(1);
                                end else begin
                                    r_cur_slot <= r_cur_slot + SLOT_W'(1);
                                end
                                r_state <= S_TICK_CMP;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_START_Q: begin
                    r_pos   <= pos;
                    r_quot  <= POS_W'(prod >> RECIP_SHIFT);
                    r_state <= S_START_W;
                end
                S_START_W: begin
                    r_valid[r_id] <= 1'b1;
                    r_slot[r_id]  <= rem[SLOT_W-1:0];
                    r_rot[r_id]   <= r_cur_rot + r_quot[ROT_W-1:0];
                    r_arg[r_id]   <= r_arg_in;
                    r_state       <= S_IDLE;
                end
                S_TICK_CMP: begin
                    r_mask  <= cmp;
                    r_valid <= r_valid & ~cmp;
                    r_state <= (cmp == '0) ? S_IDLE : S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_timer <= pick_idx;
                        r_out_arg   <= r_arg[pick_idx];
                        r_out_cause <= 1'b0;
                        r_out_last  <= (rest == '0);
                        r_mask      <= rest;
                        if (rest == '0) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_expired_timer = r_out_timer;
    assign o_expired_arg   = r_out_arg;
    assign o_cause         = r_out_cause;
    assign o_last          = r_out_last;

    a_emit_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT |-> r_mask != '0)
        else $error("report phase with nothing due");

    a_due_disarmed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT |-> (r_mask & r_valid) == '0)
        else $error("due timer still armed");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_cur_slot} < (SLOT_W + 1)'(WHEEL_SLOTS))
        else $error("wheel pointer out of range");

    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && out_free && rest == '0) |=>
            (r_state == S_IDLE && r_out_valid && r_out_last))
        else $error("final tick report not marked last");

endmodule

>>> rtl/timing_wheel_timer_table_core.sv
// ----------------------------------------------------------------------------
// timing_wheel_timer_table_core
// Hashed timing wheel over a table of sixteen timers with a ten-slot wheel.
// ----------------------------------------------------------------------------
// In the back end a start passes the quotient and table write states, a stop
// is done in the idle state and a tick passes a compare state and then emits
// one report per due timer; a report held in the single report register by a
// stalled output delays the next one. The front end drops requests that do
// nothing and buffers up to two commands, so items are accepted while the
// back end works or the output is stalled, until the queue is full. Reports
// of one tick come in increasing timer id, the final one carrying o_last.
module timing_wheel_timer_table_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [twt_pkg::REQ_W-1:0]        i_req_type,
    input  logic [twt_pkg::ID_W-1:0]         i_timer_id,
    input  logic [twt_pkg::IVL_W-1:0]        i_interval,
    input  logic signed [twt_pkg::ARG_W-1:0] i_callback_arg,
    input  logic                             i_silent_stop,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [twt_pkg::ID_W-1:0]         o_expired_timer,
    output logic signed [twt_pkg::ARG_W-1:0] o_expired_arg,
    output logic                             o_cause,
    output logic                             o_last
);
    import twt_pkg::*;

    t_q_head head;
    logic    pop;

    twt_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_timer_id     (i_timer_id),
        .i_interval     (i_interval),
        .i_callback_arg (i_callback_arg),
        .i_silent_stop  (i_silent_stop),
        .o_head         (head),
        .i_pop          (pop)
    );

    twt_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_expired_timer (o_expired_timer),
        .o_expired_arg   (o_expired_arg),
        .o_cause         (o_cause),
        .o_last          (o_last)
    );

endmodule
